// ===== rtl/psv_pkg.sv =====
`default_nettype none
package psv_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned PhaseBits   = 32;
  localparam int unsigned CntW        = 5;
  localparam int unsigned NW          = 7;
  localparam int unsigned CordW       = 34;

  localparam logic signed [CordW-1:0] CordicStart = 34'sd652032874;

  typedef enum logic {
    KIND_CIRCLE = 1'b0,
    KIND_STAR   = 1'b1
  } kind_e;

  typedef struct packed {
    logic            load;
    logic            div_start;
    logic            div_step;
    logic            cor_start;
    logic            cor_step;
    logic [CntW-1:0] k;
    logic            mul;
    logic            out_load;
    logic            next_vertex;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  // atan(2^-k) in turn units, 2^32 per turn
  function automatic logic signed [CordW-1:0] atan_turn(input logic [CntW-1:0] k);
    logic signed [CordW-1:0] v;
    unique case (k)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10680862;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41721;
      5'd15: v = 34'sd20860;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2607;
      5'd19: v = 34'sd1303;
      5'd20: v = 34'sd651;
      5'd21: v = 34'sd325;
      5'd22: v = 34'sd162;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/polygon_star_vertex_generator.sv =====
// polygon and star outline vertex generator
// in channel: one shape request per transfer (kind, center, radii, count).
// out channel: one transfer per vertex of the closed outline, in order,
// with last_vertex_o high on the final one.
// a circle gives 3..64 vertices, a star 4..64 (two per point).
// each vertex starts at the previous out transfer and runs through a setup
// step and a bit-serial phase divider with a 32-bit quotient, a setup step and
// 16 cordic iterations in a single shared rotator, then multiply, rounding
// and output.
// a new request is taken only when the previous outline has been fully
// delivered; in_ready_o is high while idle.
// a stalled receiver holds the current vertex in the output register and
// freezes all work until the transfer completes.
// reset (rst_ni low, asynchronous) returns the block to idle with no
// vertex pending.
`default_nettype none
module polygon_star_vertex_generator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               kind_i,
  input  wire logic signed [23:0] center_x_i,
  input  wire logic signed [23:0] center_y_i,
  input  wire logic [22:0]        outer_radius_i,
  input  wire logic [22:0]        inner_radius_i,
  input  wire logic [6:0]         shape_count_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [23:0]      vertex_x_o,
  output logic signed [23:0]      vertex_y_o,
  output logic                    last_vertex_o
);

  psv_pkg::cmd_t    cmd;
  psv_pkg::status_t status;

  psv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  psv_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .kind_i         (kind_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .outer_radius_i (outer_radius_i),
    .inner_radius_i (inner_radius_i),
    .shape_count_i  (shape_count_i),
    .vertex_x_o     (vertex_x_o),
    .vertex_y_o     (vertex_y_o),
    .last_vertex_o  (last_vertex_o)
  );

endmodule
`default_nettype wire

// ===== rtl/psv_ctrl.sv =====
`default_nettype none
module psv_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire psv_pkg::status_t status_i,
  output psv_pkg::cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_DIV, S_CSTART, S_CORD, S_MUL, S_PLACE, S_OUT
  } state_e;

  state_e                     state_q;
  logic [psv_pkg::CntW-1:0]   cnt_q;
  logic                       out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o             = '0;
    cmd_o.k           = cnt_q;
    cmd_o.load        = (state_q == S_IDLE) && in_valid_i;
    cmd_o.div_start   = (state_q == S_PREP);
    cmd_o.div_step    = (state_q == S_DIV);
    cmd_o.cor_start   = (state_q == S_CSTART);
    cmd_o.cor_step    = (state_q == S_CORD);
    cmd_o.mul         = (state_q == S_MUL);
    cmd_o.out_load    = (state_q == S_PLACE);
    cmd_o.next_vertex = (state_q == S_OUT) && out_ready_i && !status_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_PREP;
        S_PREP: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == psv_pkg::CntW'(psv_pkg::PhaseBits - 1)) state_q <= S_CSTART;
        end
        S_CSTART: begin
          cnt_q   <= '0;
          state_q <= S_CORD;
        end
        S_CORD: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == psv_pkg::CntW'(psv_pkg::CordicSteps - 1)) state_q <= S_MUL;
        end
        S_MUL: state_q <= S_PLACE;
        S_PLACE: begin
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= status_i.last ? S_IDLE : S_PREP;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/psv_datapath.sv =====
`default_nettype none
module psv_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire psv_pkg::cmd_t      cmd_i,
  output psv_pkg::status_t        status_o,
  input  wire logic               kind_i,
  input  wire logic signed [23:0] center_x_i,
  input  wire logic signed [23:0] center_y_i,
  input  wire logic [22:0]        outer_radius_i,
  input  wire logic [22:0]        inner_radius_i,
  input  wire logic [6:0]         shape_count_i,
  output logic signed [23:0]      vertex_x_o,
  output logic signed [23:0]      vertex_y_o,
  output logic                    last_vertex_o
);

  localparam int unsigned W = psv_pkg::CordW;
  localparam int unsigned NW = psv_pkg::NW;

  logic                   star_q;
  logic signed [23:0]     cx_q, cy_q;
  logic [22:0]            ro_q, ri_q;
  logic [NW-1:0]          n_q, i_q;
  logic [NW-1:0]          rem_q;
  logic [31:0]            quot_q;
  logic [1:0]             quad_q;
  logic signed [W-1:0]    x_q, y_q, z_q;
  logic signed [55:0]     px_q, py_q;
  logic                   last_q;

  logic [NW-1:0] n_req;
  logic [6:0]    cnt_c;
  always_comb begin
    cnt_c = shape_count_i;
    if (kind_i == psv_pkg::KIND_STAR) begin
      if (cnt_c < 7'd2) cnt_c = 7'd2;
      if (cnt_c > 7'(psv_pkg::MaxVertices / 2)) cnt_c = 7'(psv_pkg::MaxVertices / 2);
      n_req = NW'({cnt_c, 1'b0});
    end else begin
      if (cnt_c < 7'd3) cnt_c = 7'd3;
      if (cnt_c > 7'(psv_pkg::MaxVertices)) cnt_c = 7'(psv_pkg::MaxVertices);
      n_req = cnt_c;
    end
  end

  assign status_o.last = (i_q == n_q - 1'b1);

  // restoring division step, one quotient bit a cycle
  logic [NW:0] rem2;
  logic        qbit;
  assign rem2 = {rem_q, 1'b0};
  assign qbit = (rem2 >= {1'b0, n_q});

  // quadrant reduction
  logic [31:0] phase, shifted;
  always_comb begin
    phase   = quot_q - (star_q ? 32'h4000_0000 : 32'h0);
    shifted = phase + 32'h2000_0000;
  end

  // cordic step
  logic signed [W-1:0] dx, dy, at;
  assign dx = y_q >>> cmd_i.k;
  assign dy = x_q >>> cmd_i.k;
  assign at = psv_pkg::atan_turn(cmd_i.k);

  // rotation by quarter turns and clamp
  logic signed [W-1:0] c_r, s_r;
  logic signed [31:0]  c_t, s_t;
  logic signed [23:0]  rad;
  always_comb begin
    unique case (quad_q)
      2'd0: begin c_r = x_q;  s_r = y_q;  end
      2'd1: begin c_r = -y_q; s_r = x_q;  end
      2'd2: begin c_r = -x_q; s_r = -y_q; end
      default: begin c_r = y_q; s_r = -x_q; end
    endcase
    if (c_r > 34'sd1073741824) c_t = 32'sd1073741824;
    else if (c_r < -34'sd1073741824) c_t = -32'sd1073741824;
    else c_t = 32'(c_r);
    if (s_r > 34'sd1073741824) s_t = 32'sd1073741824;
    else if (s_r < -34'sd1073741824) s_t = -32'sd1073741824;
    else s_t = 32'(s_r);
    rad = (star_q && i_q[0]) ? $signed({1'b0, ri_q}) : $signed({1'b0, ro_q});
  end

  // rounding and saturation
  logic signed [56:0] rx, ry;
  logic signed [27:0] sx, sy;
  logic signed [23:0] vx, vy;
  always_comb begin
    rx = (57'(px_q) + 57'sd536870912) >>> 30;
    ry = (57'(py_q) + 57'sd536870912) >>> 30;
    sx = 28'(rx) + 28'(cx_q);
    sy = 28'(ry) + 28'(cy_q);
    if (sx > 28'sd8388607) vx = 24'sh7fffff;
    else if (sx < -28'sd8388608) vx = 24'sh800000;
    else vx = 24'(sx);
    if (sy > 28'sd8388607) vy = 24'sh7fffff;
    else if (sy < -28'sd8388608) vy = 24'sh800000;
    else vy = 24'(sy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      n_q <= NW'(3);
    end else begin
      if (cmd_i.load) begin
        i_q <= '0;
        n_q <= n_req;
      end else if (cmd_i.next_vertex) begin
        i_q <= i_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      star_q <= kind_i;
      cx_q   <= center_x_i;
      cy_q   <= center_y_i;
      ro_q   <= outer_radius_i;
      ri_q   <= inner_radius_i;
    end
    if (cmd_i.div_start) begin
      rem_q  <= i_q;
      quot_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= qbit ? NW'(rem2 - {1'b0, n_q}) : NW'(rem2);
      quot_q <= {quot_q[30:0], qbit};
    end
    if (cmd_i.cor_start) begin
      quad_q <= shifted[31:30];
      x_q    <= psv_pkg::CordicStart;
      y_q    <= '0;
      z_q    <= $signed({4'b0, shifted[29:0]}) - 34'sd536870912;
    end
    if (cmd_i.cor_step) begin
      if (!z_q[W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
    if (cmd_i.mul) begin
      px_q   <= rad * c_t;
      py_q   <= rad * s_t;
      last_q <= status_o.last;
    end
    if (cmd_i.out_load) begin
      vertex_x_o    <= vx;
      vertex_y_o    <= vy;
      last_vertex_o <= last_q;
    end
  end

endmodule
`default_nettype wire

// ===== sim/polygon_star_vertex_generator_tb.sv =====
`default_nettype none
module polygon_star_vertex_generator_tb;

  localparam int unsigned  CycleLimit = 3000000;
  localparam longint       CoordHi    = 8388607;
  localparam longint       CoordLo    = -8388608;
  localparam logic [22:0]  RadMax     = 23'h7fffff;
  localparam logic [23:0]  PosMax     = 24'h7fffff;
  localparam logic [23:0]  NegMax     = 24'h800000;

  // atan(2^-k), 2^32 per turn
  localparam longint AtanTurn [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41721, 20860
  };

  typedef struct {
    psv_pkg::kind_e     kind;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [22:0]        ro;
    logic [22:0]        ri;
    logic [6:0]         cnt;
    bit                 pinned;  // zero radius: every vertex sits on the center
  } shape_t;

  typedef struct {
    logic [23:0] x;
    logic [23:0] y;
    logic        last;
  } vertex_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               kind_i = 1'b0;
  logic signed [23:0] center_x_i = '0;
  logic signed [23:0] center_y_i = '0;
  logic [22:0]        outer_radius_i = '0;
  logic [22:0]        inner_radius_i = '0;
  logic [6:0]         shape_count_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [23:0] vertex_x_o;
  logic signed [23:0] vertex_y_o;
  logic               last_vertex_o;

  vertex_t     vertex_q [$];
  shape_t      dir_rows [$];
  int unsigned errors = 0;
  int unsigned vertices_seen = 0;
  int unsigned shapes_sent = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;

  polygon_star_vertex_generator DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .center_x_i, .center_y_i,
    .outer_radius_i, .inner_radius_i, .shape_count_i, .out_valid_o, .out_ready_i,
    .vertex_x_o, .vertex_y_o, .last_vertex_o
  );

  always #6 clk_i = ~clk_i;

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic add_row(input shape_t r);
    dir_rows = {dir_rows, r};
  endtask

  function automatic void rotate_q30(input logic [31:0] ph, output longint c, output longint s);
    logic [31:0] sh;
    logic [1:0]  q;
    longint      x, y, z, dx, dy;
    sh = ph + 32'h2000_0000;
    q  = sh[31:30];
    z  = longint'(sh[29:0]) - 536870912;
    x  = 652032874;
    y  = 0;
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTurn[k];
      end else begin
        x += dx; y -= dy; z += AtanTurn[k];
      end
    end
    case (q)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    if (c > 64'sd1073741824) c = 64'sd1073741824;
    if (c < -64'sd1073741824) c = -64'sd1073741824;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    if (s < -64'sd1073741824) s = -64'sd1073741824;
  endfunction

  function automatic logic [23:0] place_coord(input longint ctr, input longint rad,
                                              input longint t);
    longint v;
    v = ctr + ((rad * t + 64'sd536870912) >>> 30);
    if (v > CoordHi) v = CoordHi;
    if (v < CoordLo) v = CoordLo;
    return v[23:0];
  endfunction

  function automatic void predict_outline(input shape_t sh);
    int unsigned n;
    logic [63:0] num;
    logic [31:0] ph;
    longint      rad, c, s;
    vertex_t     v;
    if (sh.kind == psv_pkg::KIND_STAR) begin
      n = (sh.cnt < 2) ? 2 : ((sh.cnt > psv_pkg::MaxVertices / 2) ?
                              psv_pkg::MaxVertices / 2 : sh.cnt);
      n = n * 2;
    end else begin
      n = (sh.cnt < 3) ? 3 : ((sh.cnt > psv_pkg::MaxVertices) ?
                              psv_pkg::MaxVertices : sh.cnt);
    end
    for (int unsigned i = 0; i < n; i++) begin
      num = 64'(i) << 32;
      ph  = 32'(num / 64'(n));
      rad = longint'(sh.ro);
      if (sh.kind == psv_pkg::KIND_STAR) begin
        ph = ph - 32'h4000_0000;
        if (i[0]) rad = longint'(sh.ri);
      end
      rotate_q30(ph, c, s);
      v.last = (i + 1 == n);
      if (sh.pinned) begin
        v.x = sh.cx;
        v.y = sh.cy;
      end else begin
        v.x = place_coord(longint'(sh.cx), rad, c);
        v.y = place_coord(longint'(sh.cy), rad, s);
      end
      vertex_q = {vertex_q, v};
    end
  endfunction

  task automatic send_shape(input shape_t sh);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    kind_i         = sh.kind;
    center_x_i     = sh.cx;
    center_y_i     = sh.cy;
    outer_radius_i = sh.ro;
    inner_radius_i = sh.ri;
    shape_count_i  = sh.cnt;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_outline(sh);
    shapes_sent++;
  endtask

  function automatic shape_t random_shape();
    shape_t sh;
    sh.kind = psv_pkg::kind_e'($urandom_range(1));
    sh.cx   = 24'($urandom);
    sh.cy   = 24'($urandom);
    if ($urandom_range(9) == 0) sh.cx = $urandom_range(1) ? PosMax : NegMax;
    if ($urandom_range(9) == 0) sh.cy = $urandom_range(1) ? PosMax : NegMax;
    sh.ro = $urandom_range(2) == 0 ? 23'($urandom_range(4095)) : 23'($urandom);
    sh.ri = $urandom_range(2) == 0 ? 23'($urandom_range(4095)) : 23'($urandom);
    // mostly short outlines to keep the run brief, a few drawn over the whole count range
    sh.cnt = $urandom_range(9) == 0 ? 7'($urandom_range(127)) : 7'($urandom_range(12));
    sh.pinned = 1'b0;
    return sh;
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 36);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      vertices_seen++;
      if (vertex_q.size() == 0) begin
        report($sformatf("vertex (%0d,%0d) with nothing expected", vertex_x_o, vertex_y_o));
      end else begin
        e = vertex_q.pop_front();
        if (vertex_x_o !== e.x)
          report($sformatf("vertex_x %0d, want %0d", vertex_x_o, $signed(e.x)));
        if (vertex_y_o !== e.y)
          report($sformatf("vertex_y %0d, want %0d", vertex_y_o, $signed(e.y)));
        if (last_vertex_o !== e.last)
          report($sformatf("last_vertex %0b, want %0b", last_vertex_o, e.last));
      end
    end
  end

  initial begin
    shape_t sh;
    // counts below and above the clamps, extreme centers and radii, zero radius
    add_row('{psv_pkg::KIND_CIRCLE, 24'sd0, 24'sd0, 23'd0, 23'd0, 7'd0, 1'b1});
    add_row('{psv_pkg::KIND_STAR, -24'sd1000, 24'sd777, 23'd0, 23'd0, 7'd1, 1'b1});
    add_row('{psv_pkg::KIND_CIRCLE, 24'sd0, 24'sd0, 23'd25600, 23'd0, 7'd0, 1'b0});
    add_row('{psv_pkg::KIND_CIRCLE, 24'sd100, -24'sd100, 23'd25600, 23'd5, 7'd1, 1'b0});
    add_row('{psv_pkg::KIND_CIRCLE, 24'sd0, 24'sd0, 23'd1000, 23'd0, 7'd2, 1'b0});
    add_row('{psv_pkg::KIND_CIRCLE, 24'sd0, 24'sd0, RadMax, RadMax, 7'd3, 1'b0});
    add_row('{psv_pkg::KIND_CIRCLE, 24'sd5, 24'sd5, 23'd12345, 23'd0, 7'd4, 1'b0});
    add_row('{psv_pkg::KIND_CIRCLE, 24'sd0, 24'sd0, RadMax, 23'd0, 7'd64, 1'b0});
    add_row('{psv_pkg::KIND_CIRCLE, -24'sd3, 24'sd9, 23'd4096, 23'd0, 7'd65, 1'b0});
    add_row('{psv_pkg::KIND_CIRCLE, 24'sd0, 24'sd0, 23'd300, 23'd0, 7'd127, 1'b0});
    add_row('{psv_pkg::KIND_STAR, 24'sd0, 24'sd0, 23'd25600, 23'd12800, 7'd0, 1'b0});
    add_row('{psv_pkg::KIND_STAR, 24'sd0, 24'sd0, 23'd25600, 23'd12800, 7'd1, 1'b0});
    add_row('{psv_pkg::KIND_STAR, 24'sd0, 24'sd0, RadMax, 23'd0, 7'd2, 1'b0});
    add_row('{psv_pkg::KIND_STAR, 24'sd0, 24'sd0, 23'd1, RadMax, 7'd5, 1'b0});
    add_row('{psv_pkg::KIND_STAR, 24'sd11, 24'sd22, 23'd50000, 23'd20000, 7'd32, 1'b0});
    add_row('{psv_pkg::KIND_STAR, 24'sd0, 24'sd0, 23'd800, 23'd400, 7'd33, 1'b0});
    add_row('{psv_pkg::KIND_STAR, 24'sd0, 24'sd0, 23'd800, 23'd400, 7'd127, 1'b0});
    // saturation at both ends of both axes
    add_row('{psv_pkg::KIND_CIRCLE, PosMax, PosMax, RadMax, 23'd0, 7'd4, 1'b0});
    add_row('{psv_pkg::KIND_CIRCLE, NegMax, NegMax, RadMax, 23'd0, 7'd4, 1'b0});
    add_row('{psv_pkg::KIND_STAR, PosMax, NegMax, RadMax, RadMax, 7'd3, 1'b0});
    add_row('{psv_pkg::KIND_STAR, NegMax, PosMax, RadMax, 23'd1, 7'd4, 1'b0});
    add_row('{psv_pkg::KIND_CIRCLE, PosMax, PosMax, 23'd0, 23'd0, 7'd3, 1'b1});

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[r]) send_shape(dir_rows[r]);

    for (int unsigned j = 0; j < 108; j++) begin
      calm = (j >= 40 && j < 60);
      if (j == 90) begin
        // hold off until the current outline has drained
        @(negedge clk_i);
        in_valid_i = 1'b0;
        wait (vertex_q.size() == 0);
      end
      sh = random_shape();
      send_shape(sh);
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
    calm = 1'b0;

    wait (vertex_q.size() == 0);
    repeat (200) @(posedge clk_i);

    $display("covered %0d shape requests, %0d vertices checked", shapes_sent, vertices_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
